// ----- hdl/fpi_pkg.sv -----
// ----------------------------------------------------------------------------
// fpi_pkg: shared types and constants
// Command codes, lane widths, clamp limits and pipeline stage controls for
// the fixed-point interpolate unit.
// ----------------------------------------------------------------------------
package fpi_pkg;

    typedef enum logic {
        CMD_BLEND = 1'b0,
        CMD_CUE   = 1'b1
    } cmd_t;

    localparam int NEAR_W  = 16;
    localparam int FAR_W   = 32;
    localparam int FACT_W  = 16;
    localparam int PROD_W  = NEAR_W + FACT_W;
    localparam int FRAC_W  = 12;
    localparam int ACC_W   = 44;
    localparam int MAC_W   = ACC_W - FRAC_W;
    localparam int IR_W    = 16;
    localparam int CHAN_W  = 8;
    localparam int LANES   = 3;

    localparam logic signed [MAC_W-1:0] SAT_HI = 32'sd32767;
    localparam logic signed [MAC_W-1:0] SAT_LO = -32'sd32768;
    localparam logic signed [IR_W-1:0]  IR_HI  = 16'sh7fff;
    localparam logic signed [IR_W-1:0]  IR_LO  = 16'sh8000;
    localparam logic [CHAN_W-1:0]       CHAN_HI = 8'hff;

    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic s3_load;
    } stage_ctrl_t;

endpackage

// ----- hdl/fpi_lane.sv -----
// ----------------------------------------------------------------------------
// fpi_lane: one interpolation lane
// Three register stages: clamped difference, factor product, then the
// 44-bit accumulate with saturation to 16 bits and to one colour byte.
// ----------------------------------------------------------------------------
module fpi_lane
(
    input  logic                                    clk,
    input  fpi_pkg::stage_ctrl_t                    ctrl,
    input  logic signed [fpi_pkg::NEAR_W-1:0]       near,
    input  logic signed [fpi_pkg::FAR_W-1:0]        far,
    input  logic signed [fpi_pkg::FACT_W-1:0]       factor,
    output logic signed [fpi_pkg::MAC_W-1:0]        mac,
    output logic signed [fpi_pkg::IR_W-1:0]         ir,
    output logic        [fpi_pkg::CHAN_W-1:0]       chan
);

    logic signed [fpi_pkg::NEAR_W-1:0] near1_reg;
    logic signed [fpi_pkg::NEAR_W-1:0] near2_reg;
    logic signed [fpi_pkg::NEAR_W-1:0] diff_reg;
    logic signed [fpi_pkg::NEAR_W-1:0] diff_next;
    logic signed [fpi_pkg::FACT_W-1:0] factor1_reg;
    logic signed [fpi_pkg::PROD_W-1:0] prod_reg;
    logic signed [fpi_pkg::PROD_W-1:0] prod_next;
    logic signed [fpi_pkg::MAC_W-1:0]  mac_reg;
    logic signed [fpi_pkg::MAC_W-1:0]  mac_next;
    logic signed [fpi_pkg::IR_W-1:0]   ir_reg;
    logic signed [fpi_pkg::IR_W-1:0]   ir_next;
    logic        [fpi_pkg::CHAN_W-1:0] chan_reg;
    logic        [fpi_pkg::CHAN_W-1:0] chan_next;
    logic signed [fpi_pkg::FAR_W-1:0]  wide_diff;
    logic signed [fpi_pkg::ACC_W-1:0]  acc;

    always_comb
    begin
        wide_diff = far - fpi_pkg::FAR_W'(near);
        if (wide_diff > fpi_pkg::SAT_HI)
        begin
            diff_next = fpi_pkg::IR_HI;
        end
        else if (wide_diff < fpi_pkg::SAT_LO)
        begin
            diff_next = fpi_pkg::IR_LO;
        end
        else
        begin
            diff_next = wide_diff[fpi_pkg::NEAR_W-1:0];
        end
    end

    assign prod_next = factor1_reg * diff_reg;

    always_comb
    begin
        acc = {{(fpi_pkg::ACC_W - fpi_pkg::NEAR_W - fpi_pkg::FRAC_W){near2_reg[fpi_pkg::NEAR_W-1]}},
               near2_reg, {fpi_pkg::FRAC_W{1'b0}}}
            + fpi_pkg::ACC_W'(prod_reg);
        mac_next = acc[fpi_pkg::ACC_W-1:fpi_pkg::FRAC_W];
        if (mac_next > fpi_pkg::SAT_HI)
        begin
            ir_next = fpi_pkg::IR_HI;
        end
        else if (mac_next < fpi_pkg::SAT_LO)
        begin
            ir_next = fpi_pkg::IR_LO;
        end
        else
        begin
            ir_next = mac_next[fpi_pkg::IR_W-1:0];
        end
        if (mac_next[fpi_pkg::MAC_W-1])
        begin
            chan_next = '0;
        end
        else if (|mac_next[fpi_pkg::MAC_W-2:fpi_pkg::CHAN_W+4])
        begin
            chan_next = fpi_pkg::CHAN_HI;
        end
        else
        begin
            chan_next = mac_next[fpi_pkg::CHAN_W+3:4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            near1_reg   <= near;
            diff_reg    <= diff_next;
            factor1_reg <= factor;
        end
        if (ctrl.s2_load)
        begin
            near2_reg <= near1_reg;
            prod_reg  <= prod_next;
        end
        if (ctrl.s3_load)
        begin
            mac_reg  <= mac_next;
            ir_reg   <= ir_next;
            chan_reg <= chan_next;
        end
    end

    assign mac  = mac_reg;
    assign ir   = ir_reg;
    assign chan = chan_reg;

endmodule

// ----- hdl/fixed_point_interpolate_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_point_interpolate_unit: three-lane fixed-point interpolator
// An accepted start reaches the done strobe through the three lane stages;
// one transaction per cycle, busy never rises.
// Reset clears the stage valid bits only; the receiver cannot stall.
// Blends near values or scaled colour channels toward far values by factor.
// ----------------------------------------------------------------------------
module fixed_point_interpolate_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic signed [fpi_pkg::NEAR_W-1:0]  near_x,
    input  logic signed [fpi_pkg::NEAR_W-1:0]  near_y,
    input  logic signed [fpi_pkg::NEAR_W-1:0]  near_z,
    input  logic        [31:0]                 rgb_in,
    input  logic signed [fpi_pkg::FAR_W-1:0]   far_x,
    input  logic signed [fpi_pkg::FAR_W-1:0]   far_y,
    input  logic signed [fpi_pkg::FAR_W-1:0]   far_z,
    input  logic signed [fpi_pkg::FACT_W-1:0]  factor,
    output logic                               done,
    output logic signed [fpi_pkg::MAC_W-1:0]   mac_0,
    output logic signed [fpi_pkg::MAC_W-1:0]   mac_1,
    output logic signed [fpi_pkg::MAC_W-1:0]   mac_2,
    output logic signed [fpi_pkg::IR_W-1:0]    ir_0,
    output logic signed [fpi_pkg::IR_W-1:0]    ir_1,
    output logic signed [fpi_pkg::IR_W-1:0]    ir_2,
    output logic        [31:0]                 rgb_out
);

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic                 accept;
    fpi_pkg::stage_ctrl_t ctrl;
    fpi_pkg::cmd_t        cmd;
    logic                 cue1_reg;
    logic                 cue2_reg;
    logic                 cue3_reg;
    logic [7:0]           code1_reg;
    logic [7:0]           code2_reg;
    logic [7:0]           code3_reg;

    logic signed [fpi_pkg::NEAR_W-1:0] near_sel [fpi_pkg::LANES];
    logic signed [fpi_pkg::FAR_W-1:0]  far_sel  [fpi_pkg::LANES];
    logic signed [fpi_pkg::MAC_W-1:0]  mac_w    [fpi_pkg::LANES];
    logic signed [fpi_pkg::IR_W-1:0]   ir_w     [fpi_pkg::LANES];
    logic        [fpi_pkg::CHAN_W-1:0] chan_w   [fpi_pkg::LANES];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign cmd    = fpi_pkg::cmd_t'(command);

    assign ctrl.s1_load = accept;
    assign ctrl.s2_load = v1_reg;
    assign ctrl.s3_load = v2_reg;

    assign far_sel[0] = far_x;
    assign far_sel[1] = far_y;
    assign far_sel[2] = far_z;

    always_comb
    begin
        if (cmd == fpi_pkg::CMD_CUE)
        begin
            near_sel[0] = {4'b0000, rgb_in[7:0],   4'b0000};
            near_sel[1] = {4'b0000, rgb_in[15:8],  4'b0000};
            near_sel[2] = {4'b0000, rgb_in[23:16], 4'b0000};
        end
        else
        begin
            near_sel[0] = near_x;
            near_sel[1] = near_y;
            near_sel[2] = near_z;
        end
    end

    genvar g;
    generate
        for (g = 0; g < fpi_pkg::LANES; g++)
        begin : g_lane
            fpi_lane u_lane
            (
                .clk    (clk),
                .ctrl   (ctrl),
                .near   (near_sel[g]),
                .far    (far_sel[g]),
                .factor (factor),
                .mac    (mac_w[g]),
                .ir     (ir_w[g]),
                .chan   (chan_w[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            cue1_reg  <= (cmd == fpi_pkg::CMD_CUE);
            code1_reg <= rgb_in[31:24];
        end
        if (ctrl.s2_load)
        begin
            cue2_reg  <= cue1_reg;
            code2_reg <= code1_reg;
        end
        if (ctrl.s3_load)
        begin
            cue3_reg  <= cue2_reg;
            code3_reg <= code2_reg;
        end
    end

    assign done    = v3_reg;
    assign mac_0   = mac_w[0];
    assign mac_1   = mac_w[1];
    assign mac_2   = mac_w[2];
    assign ir_0    = ir_w[0];
    assign ir_1    = ir_w[1];
    assign ir_2    = ir_w[2];
    assign rgb_out = cue3_reg ? {code3_reg, chan_w[2], chan_w[1], chan_w[0]} : 32'h0;

    a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg |-> $past(v1_reg)) and (v3_reg |-> $past(v2_reg)))
        else $error("pipeline valid bits out of order");

    a_ir_sat_0: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mac_0 <= fpi_pkg::SAT_HI && mac_0 >= fpi_pkg::SAT_LO)
            |-> (ir_0 == mac_0[fpi_pkg::IR_W-1:0]))
        else $error("lane 0 saturation mismatch");

    a_ir_hi_1: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mac_1 > fpi_pkg::SAT_HI) |-> (ir_1 == fpi_pkg::IR_HI))
        else $error("lane 1 upper saturation mismatch");

    a_cue_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cue3_reg && mac_2[fpi_pkg::MAC_W-1]) |-> (rgb_out[23:16] == 8'h00))
        else $error("negative lane 2 not clamped to zero in colour");

endmodule

// ----- verif/tb_fixed_point_interpolate_unit.sv -----
// ----------------------------------------------------------------------------
// tb_fixed_point_interpolate_unit: self-checking bench for the interpolator
// Drives pose blend and depth cue transactions through the command handshake
// under several sender idle rates. Every done strobe is compared field by
// field with the oldest value computed by an in-bench lane model.
// ----------------------------------------------------------------------------
module tb_fixed_point_interpolate_unit;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 150;

    typedef struct {
        fpi_pkg::cmd_t                     cmd;
        logic signed [fpi_pkg::NEAR_W-1:0] nx;
        logic signed [fpi_pkg::NEAR_W-1:0] ny;
        logic signed [fpi_pkg::NEAR_W-1:0] nz;
        logic        [31:0]                rgb;
        logic signed [fpi_pkg::FAR_W-1:0]  fx;
        logic signed [fpi_pkg::FAR_W-1:0]  fy;
        logic signed [fpi_pkg::FAR_W-1:0]  fz;
        logic signed [fpi_pkg::FACT_W-1:0] fac;
    } interp_txn_t;

    typedef struct {
        logic signed [fpi_pkg::MAC_W-1:0] mac [fpi_pkg::LANES];
        logic signed [fpi_pkg::IR_W-1:0]  ir [fpi_pkg::LANES];
        logic        [31:0]               rgb;
    } interp_result_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic command;
    logic signed [fpi_pkg::NEAR_W-1:0] near_x, near_y, near_z;
    logic [31:0] rgb_in;
    logic signed [fpi_pkg::FAR_W-1:0] far_x, far_y, far_z;
    logic signed [fpi_pkg::FACT_W-1:0] factor;
    logic done;
    logic signed [fpi_pkg::MAC_W-1:0] mac_0, mac_1, mac_2;
    logic signed [fpi_pkg::IR_W-1:0] ir_0, ir_1, ir_2;
    logic [31:0] rgb_out;

    interp_txn_t    pending_txns [$];
    interp_result_t expected_results [$];
    interp_txn_t    driven_txn;
    int unsigned    sender_idle_pct;
    int unsigned    error_count;
    int unsigned    blend_count;
    int unsigned    cue_count;
    int unsigned    checked_count;
    int unsigned    quiet_cycles;

    fixed_point_interpolate_unit uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .near_x  (near_x),
        .near_y  (near_y),
        .near_z  (near_z),
        .rgb_in  (rgb_in),
        .far_x   (far_x),
        .far_y   (far_y),
        .far_z   (far_z),
        .factor  (factor),
        .done    (done),
        .mac_0   (mac_0),
        .mac_1   (mac_1),
        .mac_2   (mac_2),
        .ir_0    (ir_0),
        .ir_1    (ir_1),
        .ir_2    (ir_2),
        .rgb_out (rgb_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic longint sat_ir(longint v);
        if (v < -32768)
            return -32768;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    // keep bits 43:12 of the 44-bit wrapped sum
    function automatic longint wrap_shift(longint v);
        logic signed [fpi_pkg::MAC_W-1:0] top;
        top = v[fpi_pkg::ACC_W-1:fpi_pkg::FRAC_W];
        return longint'(top);
    endfunction

    function automatic longint blend_lane(longint nearv, longint farv, longint fac);
        longint diff;
        diff = sat_ir(wrap_shift(farv * 4096 - nearv * 4096));
        return wrap_shift(nearv * 4096 + fac * diff);
    endfunction

    function automatic interp_result_t interpolate(interp_txn_t t);
        interp_result_t r;
        longint nears [fpi_pkg::LANES];
        longint fars [fpi_pkg::LANES];
        longint m;
        longint c;
        fars[0] = longint'(t.fx);
        fars[1] = longint'(t.fy);
        fars[2] = longint'(t.fz);
        r.rgb = (t.cmd == fpi_pkg::CMD_CUE) ? {t.rgb[31:24], 24'h0} : 32'h0;
        for (int i = 0; i < fpi_pkg::LANES; i++)
        begin
            if (t.cmd == fpi_pkg::CMD_CUE)
                nears[i] = longint'(t.rgb[8*i +: 8]) * 16;
            else
                nears[i] = longint'((i == 0) ? t.nx : (i == 1) ? t.ny : t.nz);
        end
        for (int i = 0; i < fpi_pkg::LANES; i++)
        begin
            m = blend_lane(nears[i], fars[i], longint'(t.fac));
            r.mac[i] = m[fpi_pkg::MAC_W-1:0];
            r.ir[i] = fpi_pkg::IR_W'(sat_ir(m));
            if (t.cmd == fpi_pkg::CMD_CUE)
            begin
                c = (m < 0) ? 0 : (m >>> 4);
                if (c > 255)
                    c = 255;
                r.rgb[8*i +: 8] = c[7:0];
            end
        end
        return r;
    endfunction

    function automatic interp_txn_t make_txn(fpi_pkg::cmd_t cmd, int nx, int ny, int nz,
                                             logic [31:0] rgb, int fx, int fy, int fz,
                                             int fac);
        interp_txn_t t;
        t.cmd = cmd;
        t.nx = fpi_pkg::NEAR_W'(nx);
        t.ny = fpi_pkg::NEAR_W'(ny);
        t.nz = fpi_pkg::NEAR_W'(nz);
        t.rgb = rgb;
        t.fx = fx;
        t.fy = fy;
        t.fz = fz;
        t.fac = fpi_pkg::FACT_W'(fac);
        return t;
    endfunction

    function automatic logic [15:0] rand_near();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            1: return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // mixes extreme and full 32-bit targets with targets near the 16-bit range
    function automatic logic [31:0] rand_far();
        case ($urandom_range(4))
            0: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            1: return 32'($urandom_range(131071)) - 32'd65536;
            2: return 32'($urandom_range(8191)) - 32'd2048;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_factor();
        case ($urandom_range(3))
            0: return 16'($urandom_range(4096));
            1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic interp_txn_t rand_txn();
        interp_txn_t t;
        t.cmd = fpi_pkg::cmd_t'(1'($urandom_range(1)));
        t.nx = rand_near();
        t.ny = rand_near();
        t.nz = rand_near();
        t.rgb = $urandom;
        t.fx = rand_far();
        t.fy = rand_far();
        t.fz = rand_far();
        t.fac = rand_factor();
        return t;
    endfunction

    task automatic enqueue_txn(interp_txn_t t);
        pending_txns.insert(pending_txns.size(), t);
    endtask

    task automatic report_mismatch(string field, longint got, longint want);
        error_count++;
        $display("mismatch on %s: got %0d expected %0d (result %0d)",
                 field, got, want, checked_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            command <= fpi_pkg::CMD_BLEND;
            near_x <= '0;
            near_y <= '0;
            near_z <= '0;
            rgb_in <= '0;
            far_x <= '0;
            far_y <= '0;
            far_z <= '0;
            factor <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.insert(expected_results.size(), interpolate(driven_txn));
                if (driven_txn.cmd == fpi_pkg::CMD_CUE)
                    cue_count++;
                else
                    blend_count++;
            end
            if (!start || !busy)
            begin
                if (pending_txns.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    driven_txn = pending_txns.pop_front();
                    start <= 1'b1;
                    command <= driven_txn.cmd;
                    near_x <= driven_txn.nx;
                    near_y <= driven_txn.ny;
                    near_z <= driven_txn.nz;
                    rgb_in <= driven_txn.rgb;
                    far_x <= driven_txn.fx;
                    far_y <= driven_txn.fy;
                    far_z <= driven_txn.fz;
                    factor <= driven_txn.fac;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        interp_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("unexpected result: mac_0 %0d rgb_out %h", mac_0, rgb_out);
            end
            else
            begin
                want = expected_results.pop_front();
                if (mac_0 !== want.mac[0])
                    report_mismatch("mac_0", mac_0, want.mac[0]);
                if (mac_1 !== want.mac[1])
                    report_mismatch("mac_1", mac_1, want.mac[1]);
                if (mac_2 !== want.mac[2])
                    report_mismatch("mac_2", mac_2, want.mac[2]);
                if (ir_0 !== want.ir[0])
                    report_mismatch("ir_0", ir_0, want.ir[0]);
                if (ir_1 !== want.ir[1])
                    report_mismatch("ir_1", ir_1, want.ir[1]);
                if (ir_2 !== want.ir[2])
                    report_mismatch("ir_2", ir_2, want.ir[2]);
                if (rgb_out !== want.rgb)
                    report_mismatch("rgb_out", rgb_out, want.rgb);
                checked_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding",
                     expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned idle_plan [4];
        idle_plan = '{0, 85, 6, 0};
        rst_n = 1'b0;
        sender_idle_pct = 0;
        error_count = 0;
        blend_count = 0;
        cue_count = 0;
        checked_count = 0;
        quiet_cycles = 0;

        // extremes of every field, both commands, saturating colour channels
        enqueue_txn(make_txn(fpi_pkg::CMD_BLEND, 0, 0, 0, 32'h0, 0, 0, 0, 0));
        enqueue_txn(make_txn(fpi_pkg::CMD_BLEND, -32768, 32767, 0, 32'hffffffff,
                             32'h7fffffff, 32'h80000000, 0, 4096));
        enqueue_txn(make_txn(fpi_pkg::CMD_BLEND, 32767, -32768, -1, 32'h12345678,
                             32'h80000000, 32'h7fffffff, -1, 32767));
        enqueue_txn(make_txn(fpi_pkg::CMD_BLEND, -32768, -32768, -32768, 32'h0,
                             32767, -32768, 100, -32768));
        enqueue_txn(make_txn(fpi_pkg::CMD_BLEND, 100, -100, 2000, 32'h0,
                             200, -300, 1000, 2048));
        enqueue_txn(make_txn(fpi_pkg::CMD_BLEND, 32767, 32767, 32767, 32'hffffffff,
                             32767, 32767, 32767, 4096));
        enqueue_txn(make_txn(fpi_pkg::CMD_CUE, 0, 0, 0, 32'h0, 0, 0, 0, 0));
        enqueue_txn(make_txn(fpi_pkg::CMD_CUE, 32767, -32768, 0, 32'hffffffff,
                             32'h7fffffff, 32'h80000000, 0, 4096));
        enqueue_txn(make_txn(fpi_pkg::CMD_CUE, -1, -1, -1, 32'hab80ff00,
                             4080, 0, -4096, 4096));
        enqueue_txn(make_txn(fpi_pkg::CMD_CUE, 0, 0, 0, 32'h00ffffff,
                             -100000, 100000, 4080, 32767));
        enqueue_txn(make_txn(fpi_pkg::CMD_CUE, 0, 0, 0, 32'hff102030,
                             32'h80000000, 32'h7fffffff, 2000, -32768));
        enqueue_txn(make_txn(fpi_pkg::CMD_CUE, 0, 0, 0, 32'h5a7f4020,
                             1000, 2000, 3000, 2048));
        enqueue_txn(make_txn(fpi_pkg::CMD_CUE, 0, 0, 0, 32'hffffffff,
                             4095, 4096, 4111, 0));
        enqueue_txn(make_txn(fpi_pkg::CMD_BLEND, 1, -1, 16384, 32'hdeadbeef,
                             -1, 1, -16384, -1));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (idle_plan[p])
        begin
            sender_idle_pct = idle_plan[p];
            repeat (RANDOM_PER_PHASE) enqueue_txn(rand_txn());
            while (pending_txns.size() > 0)
                @(posedge clk);
        end

        while (expected_results.size() > 0 || start)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d pose blend and %0d depth cue transactions", blend_count,
                 cue_count);
        $display("compared %0d results across four idle phases", checked_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/fpi_pkg.sv
hdl/fpi_lane.sv
hdl/fixed_point_interpolate_unit.sv
verif/tb_fixed_point_interpolate_unit.sv
